// ===== rtl/core/flat_lambert_light_shader_core_assert.svh =====
`ifndef FLAT_LAMBERT_LIGHT_SHADER_CORE_ASSERT_SVH
`define FLAT_LAMBERT_LIGHT_SHADER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define FLS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define FLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/fls_pkg.sv =====
package fls_pkg;

  localparam int CW  = 24;   // coordinate width, Q12.12
  localparam int SW  = 16;   // color / sum width, Q8.8
  localparam int VW  = 51;   // vector component width into the unitizer
  localparam int MW  = 30;   // normalized magnitude width
  localparam int SQW = 62;   // sum of squares width
  localparam int RW  = 31;   // square root width
  localparam int QW  = 16;   // quotient bits per unit component
  localparam int DW  = 46;   // divider remainder width
  localparam int UW  = 17;   // unit component width, Q1.15 signed
  localparam int NGRP = 7;   // 8-bit groups in the leading-one search

  localparam int UNIT_LAT = 7 + RW + QW;
  localparam int NSTAGE   = UNIT_LAT + 6;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [SW-1:0] SUM_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    LK_AMBIENT = 2'd0,
    LK_DIR     = 2'd1,
    LK_POINT   = 2'd2,
    LK_NONE    = 2'd3
  } light_kind_e;

  typedef enum logic [2:0] {
    CFG_KIND  = 3'd0,
    CFG_RED   = 3'd1,
    CFG_GREEN = 3'd2,
    CFG_BLUE  = 3'd3,
    CFG_VX    = 3'd4,
    CFG_VY    = 3'd5,
    CFG_VZ    = 3'd6
  } cfg_idx_e;

  typedef logic signed [VW-1:0] vcomp_t;
  typedef logic signed [UW-1:0] ucomp_t;

endpackage

// ===== rtl/core/flat_lambert_light_shader_core.sv =====
// Throughput: one triangle per cycle while the skid is empty; the square root and divider are fully pipelined.
// A skid register holds one result while the output stalls; the pipeline freezes then.
// Reset (rst_ni low, asynchronous): light registers clear to 0 (ambient, black),
// all valid bits and the skid clear; no clearing pass is needed.
module flat_lambert_light_shader_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // va_x, va_y, va_z, vb_x, vb_y, vb_z, vc_x, vc_y, vc_z, sum_in_red, sum_in_green, sum_in_blue
  input  logic [263:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sum_out_red, sum_out_green, sum_out_blue
  output logic [47:0] m_axis_tdata,
  // degenerate
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  fls_pkg::cfg_idx_e cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import fls_pkg::*;
  `include "flat_lambert_light_shader_core_assert.svh"

  light_kind_e          kind_q;
  logic [SW-1:0]        color_q [3];
  logic signed [CW-1:0] lvec_q  [3];

  logic                 en;
  logic                 vld_q  [NSTAGE];
  logic [3*SW-1:0]      side_q [NSTAGE];

  logic signed [CW-1:0] va [3], vb [3], vc [3];
  logic signed [24:0]   e1_d [3], e2_d [3];
  logic signed [26:0]   lv_d [3];

  logic signed [24:0]   e1_q [3], e2_q [3];
  logic signed [26:0]   lv1_q [3], lv2_q [3], lv3_q [3];
  logic signed [49:0]   p_q [6];
  vcomp_t               nrm_q [3];
  vcomp_t               lvx [3];

  ucomp_t               un [3], ul [3];
  logic                 zn, zl;

  logic signed [33:0]   dp_q [3];
  logic                 zero1_q;
  logic signed [35:0]   dsum;
  logic signed [21:0]   dsh;
  logic [16:0]          inten_d;
  logic                 degen_d;
  logic [16:0]          inten_q;
  logic                 degen2_q, degen3_q;
  logic [32:0]          prod_q [3];

  logic [3*SW-1:0]      res_data;
  logic [16:0]          acc [3];

  logic                 out_vld_q, skid_vld_q;
  logic [3*SW-1:0]      out_data_q, skid_data_q;
  logic                 out_degen_q, skid_degen_q;
  logic                 take;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= LK_AMBIENT;
      for (int i = 0; i < 3; i++) begin
        color_q[i] <= '0;
        lvec_q[i]  <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KIND:  kind_q     <= light_kind_e'(cfg_data_i[1:0]);
        CFG_RED:   color_q[0] <= cfg_data_i[SW-1:0];
        CFG_GREEN: color_q[1] <= cfg_data_i[SW-1:0];
        CFG_BLUE:  color_q[2] <= cfg_data_i[SW-1:0];
        CFG_VX:    lvec_q[0]  <= cfg_data_i;
        CFG_VY:    lvec_q[1]  <= cfg_data_i;
        CFG_VZ:    lvec_q[2]  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // the whole pipeline advances unless the skid holds a beat
  assign en            = ~skid_vld_q;
  assign s_axis_tready = en;

  // edges and light vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i]   = s_axis_tdata[CW*i +: CW];
      vb[i]   = s_axis_tdata[3*CW + CW*i +: CW];
      vc[i]   = s_axis_tdata[6*CW + CW*i +: CW];
      e1_d[i] = 25'(vb[i]) - 25'(va[i]);
      e2_d[i] = 25'(vc[i]) - 25'(va[i]);
      if (kind_q == LK_POINT) begin
        lv_d[i] = 27'(lvec_q[i]) + (27'(lvec_q[i]) <<< 1)
                - 27'(va[i]) - 27'(vb[i]) - 27'(vc[i]);
      end else begin
        lv_d[i] = 27'(lvec_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTAGE; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int s = 1; s < NSTAGE; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s_axis_tdata[9*CW +: 3*SW];
      for (int s = 1; s < NSTAGE; s++) side_q[s] <= side_q[s-1];
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      lv1_q <= lv_d;
      p_q[0] <= e1_q[1] * e2_q[2];
      p_q[1] <= e1_q[2] * e2_q[1];
      p_q[2] <= e1_q[2] * e2_q[0];
      p_q[3] <= e1_q[0] * e2_q[2];
      p_q[4] <= e1_q[0] * e2_q[1];
      p_q[5] <= e1_q[1] * e2_q[0];
      lv2_q <= lv1_q;
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= VW'(p_q[2*i]) - VW'(p_q[2*i+1]);
      end
      lv3_q <= lv2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) lvx[i] = VW'(lv3_q[i]);
  end

  fls_unitize u_unit_nrm (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (nrm_q),
    .unit_o (un),
    .zero_o (zn)
  );

  fls_unitize u_unit_lgt (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (lvx),
    .unit_o (ul),
    .zero_o (zl)
  );

  // intensity
  always_comb begin
    dsum = 36'(dp_q[0]) + 36'(dp_q[1]) + 36'(dp_q[2]);
    dsh  = 22'(dsum >>> 14);
    unique case (kind_q)
      LK_AMBIENT: begin
        inten_d = ONE_Q16;
        degen_d = 1'b0;
      end
      LK_DIR, LK_POINT: begin
        degen_d = zero1_q;
        if (zero1_q || dsum <= 0) begin
          inten_d = '0;
        end else if (dsh > 22'(ONE_Q16)) begin
          inten_d = ONE_Q16;
        end else begin
          inten_d = dsh[16:0];
        end
      end
      default: begin
        inten_d = '0;
        degen_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) dp_q[i] <= un[i] * ul[i];
      zero1_q  <= zn | zl;
      inten_q  <= inten_d;
      degen2_q <= degen_d;
      for (int i = 0; i < 3; i++) prod_q[i] <= color_q[i] * inten_q;
      degen3_q <= degen2_q;
    end
  end

  // saturating add
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 17'(side_q[NSTAGE-1][SW*i +: SW]) + 17'(prod_q[i] >> 16);
      res_data[SW*i +: SW] = acc[i][16] ? SUM_MAX : acc[i][SW-1:0];
    end
  end

  // output register and skid
  assign take = out_vld_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) skid_vld_q <= 1'b0;
    end else if (vld_q[NSTAGE-1]) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_data_q  <= skid_data_q;
        out_degen_q <= skid_degen_q;
      end
    end else if (vld_q[NSTAGE-1]) begin
      if (!out_vld_q || take) begin
        out_data_q  <= res_data;
        out_degen_q <= degen3_q;
      end else begin
        skid_data_q  <= res_data;
        skid_degen_q <= degen3_q;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_degen_q;

  `FLS_ASSERT_IMPL(a_skid_implies_out, skid_vld_q, out_vld_q)
  `FLS_ASSERT_IMPL(a_skid_blocks_input, skid_vld_q, !s_axis_tready)
  `FLS_ASSERT_NEXT(a_stall_fills_skid,
    vld_q[NSTAGE-1] && !skid_vld_q && out_vld_q && !m_axis_tready, skid_vld_q)
  `FLS_ASSERT_IMPL(a_ambient_not_degen, out_vld_q && kind_q == LK_AMBIENT, !out_degen_q)

endmodule

// ===== rtl/core/fls_unitize.sv =====
module fls_unitize (
  input  logic            clk_i,
  input  logic            en_i,
  input  fls_pkg::vcomp_t vec_i [3],
  output fls_pkg::ucomp_t unit_o [3],
  output logic            zero_o
);
  import fls_pkg::*;

  // magnitude and sign
  logic [2:0][VW-1:0] mag_a_q;
  logic [2:0]         neg_a_q;
  // leading-one search, group level
  logic [2:0][VW-1:0] mag_b_q;
  logic [2:0]         neg_b_q;
  logic [NGRP-1:0]    grp_nz_b_q;
  logic [2:0]         grp_pos_b_q [NGRP];
  // leading-one position
  logic [2:0][VW-1:0] mag_c_q;
  logic [2:0]         neg_c_q;
  logic [5:0]         pos_c_q;
  logic               zero_c_q;
  // normalized
  logic [2:0][MW-1:0] mag_d_q;
  logic [2:0]         neg_d_q;
  logic               zero_d_q;
  // squares
  logic [2:0][MW-1:0]  mag_e_q;
  logic [2:0]          neg_e_q;
  logic                zero_e_q;
  logic [2:0][2*MW-1:0] sq_e_q;
  // sum of squares
  logic [2:0][MW-1:0] mag_f_q;
  logic [2:0]         neg_f_q;
  logic               zero_f_q;
  logic [SQW-1:0]     sum_f_q;
  // square root steps
  logic [SQW-1:0]     sq_rem_q  [RW];
  logic [RW-1:0]      sq_root_q [RW];
  logic [2:0][MW-1:0] sq_mag_q  [RW];
  logic [2:0]         sq_neg_q  [RW];
  logic               sq_zero_q [RW];
  // divider steps
  logic [2:0][DW-1:0] dv_rem_q  [QW];
  logic [2:0][QW-1:0] dv_quo_q  [QW];
  logic [RW-1:0]      dv_s_q    [QW];
  logic [2:0]         dv_neg_q  [QW];
  logic               dv_zero_q [QW];
  // output
  ucomp_t             unit_q [3];
  logic               zero_q;

  logic [NGRP*8-1:0]  or_pad;
  logic [2:0]         gpos_d [NGRP];
  logic [5:0]         pos_d;

  assign or_pad = (NGRP*8)'(mag_a_q[0] | mag_a_q[1] | mag_a_q[2]);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      gpos_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (or_pad[8*g+b]) gpos_d[g] = 3'(b);
      end
    end
  end

  always_comb begin
    pos_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_nz_b_q[g]) pos_d = 6'(8*g) + 6'(grp_pos_b_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg_a_q[i] <= vec_i[i][VW-1];
        mag_a_q[i] <= vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
      end
      mag_b_q <= mag_a_q;
      neg_b_q <= neg_a_q;
      for (int g = 0; g < NGRP; g++) begin
        grp_nz_b_q[g]  <= |or_pad[8*g +: 8];
        grp_pos_b_q[g] <= gpos_d[g];
      end
      mag_c_q  <= mag_b_q;
      neg_c_q  <= neg_b_q;
      pos_c_q  <= pos_d;
      zero_c_q <= ~|grp_nz_b_q;
      for (int i = 0; i < 3; i++) begin
        if (pos_c_q > 6'(MW-1)) begin
          mag_d_q[i] <= MW'(mag_c_q[i] >> (pos_c_q - 6'(MW-1)));
        end else begin
          mag_d_q[i] <= MW'(mag_c_q[i] << (6'(MW-1) - pos_c_q));
        end
      end
      neg_d_q  <= neg_c_q;
      zero_d_q <= zero_c_q;
      for (int i = 0; i < 3; i++) begin
        sq_e_q[i] <= mag_d_q[i] * mag_d_q[i];
      end
      mag_e_q  <= mag_d_q;
      neg_e_q  <= neg_d_q;
      zero_e_q <= zero_d_q;
      sum_f_q  <= SQW'(sq_e_q[0]) + SQW'(sq_e_q[1]) + SQW'(sq_e_q[2]);
      mag_f_q  <= mag_e_q;
      neg_f_q  <= neg_e_q;
      zero_f_q <= zero_e_q;
    end
  end

  // one root bit per step, most significant first
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [SQW-1:0]     rin;
    logic [RW-1:0]      qin;
    logic [2:0][MW-1:0] min;
    logic [2:0]         nin;
    logic               zin;
    logic [SQW-1:0]     trial;
    if (k == 0) begin : g_first
      assign rin = sum_f_q;
      assign qin = '0;
      assign min = mag_f_q;
      assign nin = neg_f_q;
      assign zin = zero_f_q;
    end else begin : g_next
      assign rin = sq_rem_q[k-1];
      assign qin = sq_root_q[k-1];
      assign min = sq_mag_q[k-1];
      assign nin = sq_neg_q[k-1];
      assign zin = sq_zero_q[k-1];
    end
    assign trial = (SQW'(qin) << (RW - k)) + (SQW'(1) << (2 * (RW - 1 - k)));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rin >= trial) begin
          sq_rem_q[k]  <= rin - trial;
          sq_root_q[k] <= qin | (RW'(1) << (RW - 1 - k));
        end else begin
          sq_rem_q[k]  <= rin;
          sq_root_q[k] <= qin;
        end
        sq_mag_q[k]  <= min;
        sq_neg_q[k]  <= nin;
        sq_zero_q[k] <= zin;
      end
    end
  end

  // one quotient bit per step for each component
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][DW-1:0] rin;
    logic [2:0][QW-1:0] qin;
    logic [RW-1:0]      sin;
    logic [2:0]         nin;
    logic               zin;
    logic [DW-1:0]      trial;
    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_num
        assign rin[i] = DW'({sq_mag_q[RW-1][i], 15'b0});
      end
      assign qin = '0;
      assign sin = sq_root_q[RW-1];
      assign nin = sq_neg_q[RW-1];
      assign zin = sq_zero_q[RW-1];
    end else begin : g_next
      assign rin = dv_rem_q[j-1];
      assign qin = dv_quo_q[j-1];
      assign sin = dv_s_q[j-1];
      assign nin = dv_neg_q[j-1];
      assign zin = dv_zero_q[j-1];
    end
    assign trial = DW'(sin) << (QW - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (rin[i] >= trial) begin
            dv_rem_q[j][i] <= rin[i] - trial;
            dv_quo_q[j][i] <= qin[i] | (QW'(1) << (QW - 1 - j));
          end else begin
            dv_rem_q[j][i] <= rin[i];
            dv_quo_q[j][i] <= qin[i];
          end
        end
        dv_s_q[j]    <= sin;
        dv_neg_q[j]  <= nin;
        dv_zero_q[j] <= zin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        unit_q[i] <= dv_neg_q[QW-1][i] ? -UW'(dv_quo_q[QW-1][i]) : UW'(dv_quo_q[QW-1][i]);
      end
      zero_q <= dv_zero_q[QW-1];
    end
  end

  assign unit_o = unit_q;
  assign zero_o = zero_q;

endmodule

// ===== dv/flat_lambert_light_shader_core_tb.sv =====
module flat_lambert_light_shader_core_tb;
  import fls_pkg::*;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        degen;
  } shade_t;

  class shade_sb;
    light_kind_e        kind;
    logic [15:0]        color [3];
    logic signed [23:0] lvec [3];
    shade_t             expq [$];
    int                 errors;
    int                 n_in;
    int                 n_out;
    int                 n_degen;
    int                 n_lit;

    function new();
      kind = LK_AMBIENT;
      foreach (color[i]) color[i] = '0;
      foreach (lvec[i]) lvec[i] = '0;
      errors = 0;
      n_in = 0;
      n_out = 0;
      n_degen = 0;
      n_lit = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [23:0] d);
      case (idx)
        CFG_KIND:  kind = light_kind_e'(d[1:0]);
        CFG_RED:   color[0] = d[15:0];
        CFG_GREEN: color[1] = d[15:0];
        CFG_BLUE:  color[2] = d[15:0];
        CFG_VX:    lvec[0] = d;
        CFG_VY:    lvec[1] = d;
        CFG_VZ:    lvec[2] = d;
        default: ;
      endcase
    endfunction

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // unit vector in Q1.15; 0 for the zero vector
    function bit unitize(input longint v [3], output longint u [3]);
      longint unsigned mag [3];
      longint unsigned mx;
      longint unsigned sq;
      longint unsigned s;
      longint          q;
      bit              ng [3];
      mx = 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        ng[i] = v[i] < 0;
        mag[i] = ng[i] ? longint'(-v[i]) : longint'(v[i]);
        if (mag[i] > mx) mx = mag[i];
        u[i] = 0;
      end
      if (mx == 0) return 1'b0;
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx = mx << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
      s = isqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = longint'((mag[i] << 15) / s);
        u[i] = ng[i] ? -q : q;
      end
      return 1'b1;
    endfunction

    function void note(logic [263:0] d);
      logic signed [23:0] crd [9];
      longint             a [3], b [3], c [3], e1 [3], e2 [3];
      longint             nrm [3], lv [3], un [3], ul [3];
      longint             dotp;
      longint             inten;
      longint unsigned    t;
      logic [15:0]        sin [3];
      logic [15:0]        sout [3];
      shade_t             r;
      bit                 okn, okl;
      for (int i = 0; i < 9; i++) crd[i] = d[24*i +: 24];
      for (int i = 0; i < 3; i++) begin
        sin[i] = d[216 + 16*i +: 16];
        a[i] = crd[i];
        b[i] = crd[3+i];
        c[i] = crd[6+i];
        e1[i] = b[i] - a[i];
        e2[i] = c[i] - a[i];
      end
      inten = 0;
      r.degen = 1'b0;
      if (kind == LK_AMBIENT) begin
        inten = 65536;
      end else if (kind == LK_DIR || kind == LK_POINT) begin
        nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int i = 0; i < 3; i++) begin
          lv[i] = lvec[i];
          if (kind == LK_POINT) lv[i] = 3 * lv[i] - (a[i] + b[i] + c[i]);
        end
        okn = unitize(nrm, un);
        okl = unitize(lv, ul);
        if (!okn || !okl) begin
          r.degen = 1'b1;
        end else begin
          dotp = un[0] * ul[0] + un[1] * ul[1] + un[2] * ul[2];
          if (dotp > 0) begin
            inten = dotp >>> 14;
            if (inten > 65536) inten = 65536;
          end
        end
      end
      if (inten > 0) n_lit++;
      for (int i = 0; i < 3; i++) begin
        t = longint'(sin[i]) + ((longint'(color[i]) * inten) >> 16);
        sout[i] = (t > 65535) ? 16'hFFFF : t[15:0];
      end
      r.red = sout[0];
      r.green = sout[1];
      r.blue = sout[2];
      if (r.degen) n_degen++;
      expq.push_back(r);
      n_in++;
    endfunction

    function void report(string msg);
      $display("MISMATCH beat %0d: %s", n_out, msg);
      errors++;
    endfunction

    function void check(logic [47:0] d, logic dg);
      shade_t e;
      if (expq.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = expq.pop_front();
      if (d[15:0] !== e.red)
        report($sformatf("red %h exp %h", d[15:0], e.red));
      if (d[31:16] !== e.green)
        report($sformatf("green %h exp %h", d[31:16], e.green));
      if (d[47:32] !== e.blue)
        report($sformatf("blue %h exp %h", d[47:32], e.blue));
      if (dg !== e.degen)
        report($sformatf("degenerate %b exp %b", dg, e.degen));
      n_out++;
    endfunction
  endclass

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int LIMIT = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [263:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [47:0]   m_axis_tdata;
  logic          m_axis_tuser;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  cfg_idx_e      cfg_index_i = CFG_KIND;
  logic [23:0]   cfg_data_i = '0;

  shade_sb sb = new();
  bit  quiet;
  int  hold_req;
  int  cycles;
  int  n_phase;

  flat_lambert_light_shader_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("flat_lambert_light_shader_core_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
      end
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [23:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expq.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_light(light_kind_e k, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [23:0] x, logic [23:0] y, logic [23:0] z);
    drain();
    cfg_write(CFG_KIND, {22'($urandom_range(4194303)), 2'(k)});
    cfg_write(CFG_RED, {8'($urandom_range(255)), r});
    cfg_write(CFG_GREEN, {8'h00, g});
    cfg_write(CFG_BLUE, {8'hFF, b});
    cfg_write(CFG_VX, x);
    cfg_write(CFG_VY, y);
    cfg_write(CFG_VZ, z);
    n_phase++;
  endtask

  task automatic send_tri(logic [23:0] v [9], logic [15:0] s [3]);
    logic [263:0] d;
    for (int i = 0; i < 9; i++) d[24*i +: 24] = v[i];
    for (int i = 0; i < 3; i++) d[216 + 16*i +: 16] = s[i];
    while (!quiet && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic idle_in();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rnd_coord();
    int w;
    logic [23:0] v;
    w = $urandom_range(24, 1);
    v = 24'($urandom);
    case ($urandom_range(19))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      default: return (w == 24) ? v : 24'(signed'(v[23:0] << (24 - w)) >>> (24 - w));
    endcase
  endfunction

  function automatic logic [15:0] rnd_sum();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic rnd_tri();
    logic [23:0] v [9];
    logic [15:0] s [3];
    int          sc;
    sc = $urandom_range(23, 0);
    for (int i = 0; i < 9; i++) v[i] = rnd_coord();
    // mostly compact triangles around a random anchor
    if ($urandom_range(99) < 60) begin
      for (int i = 3; i < 9; i++)
        v[i] = v[i % 3] + 24'(signed'(24'($urandom)) >>> sc);
    end
    case ($urandom_range(19))
      0: for (int i = 0; i < 3; i++) v[3+i] = v[i];
      1: for (int i = 0; i < 3; i++) v[6+i] = 24'(2 * v[3+i] - v[i]);
      default: ;
    endcase
    for (int i = 0; i < 3; i++) s[i] = rnd_sum();
    send_tri(v, s);
  endtask

  task automatic dir_tri(logic [23:0] ax, logic [23:0] ay, logic [23:0] az,
                         logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
                         logic [23:0] cx, logic [23:0] cy, logic [23:0] cz,
                         logic [15:0] s0, logic [15:0] s1, logic [15:0] s2);
    logic [23:0] v [9];
    logic [15:0] s [3];
    v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    s = '{s0, s1, s2};
    send_tri(v, s);
  endtask

  task automatic directed();
    // reset config: ambient, black
    dir_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 16'hFFFF, 16'h0000);
    dir_tri(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
            24'hFFFFFF, 0, 24'h000001, 16'hFFFF, 16'h8000, 16'h0001);
    set_light(LK_AMBIENT, 16'hFFFF, 16'h0001, 16'h8000, 0, 0, 0);
    dir_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 16'h0000, 16'hFFFF, 16'h7FFF);
    dir_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFE, 16'h8000);
    set_light(LK_DIR, 16'hFFFF, 16'h8000, 16'h0100, 0, 0, 24'h001000);
    dir_tri(0, 0, 0, 24'h001000, 0, 0, 0, 24'h001000, 0, 0, 0, 0);
    dir_tri(0, 0, 0, 0, 24'h001000, 0, 24'h001000, 0, 0, 16'h1000, 0, 16'hFFFF);
    dir_tri(0, 0, 0, 24'h001000, 24'h001000, 0, 24'h002000, 24'h002000, 0, 1, 2, 3);
    dir_tri(24'h800000, 24'h800000, 0, 24'h7FFFFF, 24'h800000, 0,
            24'h800000, 24'h7FFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    dir_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0);
    dir_tri(5, 5, 5, 24'h7FFFFF, 24'h800000, 24'h123456, 24'h800000, 24'h7FFFFF,
            24'hABCDEF, 16'h00FF, 16'hFF00, 16'h5A5A);
    set_light(LK_DIR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0);
    dir_tri(0, 0, 0, 24'h001000, 0, 0, 0, 24'h001000, 0, 16'h0100, 0, 0);
    set_light(LK_POINT, 16'hFFFF, 16'h4000, 16'hC000, 24'h001000, 24'h001000, 24'h800000);
    dir_tri(0, 0, 0, 24'h003000, 0, 0, 0, 24'h003000, 0, 0, 0, 0);
    dir_tri(0, 24'h003000, 24'h800000, 24'h003000, 0, 24'h800000,
            0, 0, 24'h800000, 16'h0010, 16'h0020, 16'h0030);
    dir_tri(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
            24'h800000, 24'h7FFFFF, 24'h800000, 16'hFFFF, 0, 16'hFFFF);
    set_light(LK_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h800000, 1);
    dir_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 16'hABCD, 16'hFFFF, 0);
    // write to an unused index must change nothing
    drain();
    cfg_write(cfg_idx_e'(CFG_UNUSED), 24'hFFFFFF);
    dir_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0001, 16'h0002, 16'h0003);
    idle_in();
  endtask

  function automatic logic [15:0] rnd_color();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    light_kind_e k;
    cycles = 0;
    quiet = 1'b0;
    hold_req = 0;
    n_phase = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0: k = LK_AMBIENT;
        1, 3: k = LK_DIR;
        2, 4: k = LK_POINT;
        default: k = LK_NONE;
      endcase
      set_light(k, rnd_color(), rnd_color(), rnd_color(),
                rnd_coord(), rnd_coord(), rnd_coord());
      quiet = (p == 4);
      if (p == 3) hold_req = 300;
      repeat ((p == 3) ? 115 : 55) rnd_tri();
      idle_in();
    end
    quiet = 1'b0;
    drain();
    repeat (80) @(posedge clk_i);
    $display("%0d triangles in %0d light settings, %0d results checked",
             sb.n_in, n_phase, sb.n_out);
    $display("%0d lit, %0d degenerate, %0d mismatches",
             sb.n_lit, sb.n_degen, sb.errors);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("flat_lambert_light_shader_core_tb: clean");
    end else begin
      $display("flat_lambert_light_shader_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fls_pkg.sv
rtl/core/fls_unitize.sv
rtl/core/flat_lambert_light_shader_core.sv
dv/flat_lambert_light_shader_core_tb.sv
